>>> rtl/core/sli_pkg.sv
// Shared types and constants for the sorted list insert/remove block.
// Depends on nothing; imported by every module under rtl/core.
package sli_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

>>> rtl/core/sli_ctrl.sv
// Controller for the sorted list block: two-state sequencer and output beat valid.
// Depends on sli_pkg.
module sli_ctrl
    import sli_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;

    // Take a new beat only when the output slot is free or drains this edge
    assign accept = o_in_ready & i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = ~r_out_valid | i_out_ready;
                o_cmd.capture = ~r_out_valid | i_out_ready;
            end
            S_UPDATE: begin
                o_cmd.commit = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.capture = o_cmd.capture & i_in_valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // The update cycle must always find the output slot empty
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> !r_out_valid)
        else $error("update with output slot still full");

    // Every accepted beat produces a result: the update state follows and sets the output valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 r_out_valid)
        else $error("result missing after accepted beat");

endmodule

>>> rtl/core/sli_datapath.sv
// Datapath for the sorted list block: cell array with parallel compare and shift,
// entry count and result register. Depends on sli_pkg.
module sli_datapath
    import sli_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic                      i_action,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_ok,
    output logic [COUNT_W-1:0]        o_count,
    output logic                      o_is_empty
);

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic signed [VALUE_W-1:0] r_value;
    t_action                   r_act;
    logic [CAPACITY-1:0]       r_lt;
    logic [CAPACITY-1:0]       r_eq;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_ok;
    logic [COUNT_W-1:0]        r_out_count;
    logic                      r_empty;

    logic [CAPACITY-1:0]       lt_now;
    logic [CAPACITY-1:0]       eq_now;
    logic [CAPACITY-1:0]       bnd;
    logic                      full;
    logic                      found;
    logic                      do_ins;
    logic                      do_rem;

    // Per-cell compare against the incoming value; cells past the count never match
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cmp
        logic in_use;
        assign in_use    = (CNT_W'(g) < r_count);
        assign lt_now[g] = in_use & (r_cell[g] < i_value);
        assign eq_now[g] = in_use & (r_cell[g] == i_value);
        if (g == 0) begin : g_first
            assign bnd[g] = ~r_lt[g];
        end else begin : g_rest
            assign bnd[g] = ~r_lt[g] & r_lt[g-1];
        end
    end

    assign full   = (r_count == CNT_W'(CAPACITY));
    assign found  = |(bnd & r_eq);
    assign do_ins = i_cmd.commit & (r_act == ACT_INSERT) & ~full;
    assign do_rem = i_cmd.commit & (r_act == ACT_REMOVE) & found;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_value <= i_value;
            r_act   <= t_action'(i_action);
            r_lt    <= lt_now;
            r_eq    <= eq_now;
        end
        if (i_cmd.commit) begin
            r_ok        <= (r_act == ACT_INSERT) ? ~full : found;
            r_out_count <= COUNT_W'(n_count);
            r_empty     <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Shift the cells: insert opens a gap at the boundary, remove closes it
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] from_below;
        logic signed [VALUE_W-1:0] from_above;
        if (g == 0) begin : g_lo
            assign from_below = r_value;
        end else begin : g_lo_rest
            assign from_below = r_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign from_above = r_cell[g];
        end else begin : g_hi_rest
            assign from_above = r_cell[g+1];
        end

        always_ff @(posedge i_clk) begin
            if (do_ins && !r_lt[g]) begin
                r_cell[g] <= bnd[g] ? r_value : from_below;
            end else if (do_rem && !r_lt[g]) begin
                r_cell[g] <= from_above;
            end
        end
    end

    assign o_ok       = r_ok;
    assign o_count    = r_out_count;
    assign o_is_empty = r_empty;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Sorted cells give a prefix of less-than flags, hence a single boundary;
    // a full store with every cell below the operand has none
    a_one_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !full) |-> $onehot(bnd))
        else $error("less-than flags not a prefix");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CNT_W'(1)) && r_ok)
        else $error("insert did not add one entry");

endmodule

>>> rtl/core/sorted_list_insert_remove.sv
// Sorted multiset store: one result beat per input beat, valid once the update state
// has committed it. A new beat waits until the last has passed its compare and shift
// steps over the cell array, and while the output slot is full and not draining.
// Reset (synchronous, active low) empties the store, idles the sequencer and clears
// the output valid; cell contents are not cleared and are only compared below the entry count.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
module sorted_list_insert_remove
    import sli_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_ok,
    output logic [COUNT_W-1:0]        o_count,
    output logic                      o_is_empty
);

    t_dp_cmd cmd;

    sli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    sli_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_action   (i_action),
        .i_value    (i_value),
        .o_ok       (o_ok),
        .o_count    (o_count),
        .o_is_empty (o_is_empty)
    );

endmodule
